// ===== hdl/ps2kbd_pkg.sv =====
package ps2kbd_pkg;

    localparam int unsigned CODE_W    = 8;
    localparam int unsigned KEY_IDX_W = 7;
    localparam int unsigned STD_COUNT = 63;
    localparam int unsigned EXT_COUNT = 19;

    localparam logic [CODE_W-1:0] CODE_RELEASE = 8'hF0;
    localparam logic [CODE_W-1:0] CODE_EXTEND  = 8'hE0;
    localparam logic [CODE_W-1:0] CODE_ACK     = 8'hFA;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_ACK     = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic              is_byte;
        logic [CODE_W-1:0] code_byte;
        logic              from_host;
    } in_item_t;

    typedef struct packed {
        event_kind_t          event_kind;
        logic                 extended_key;
        logic [CODE_W-1:0]    scan_code;
        logic                 key_found;
        logic [KEY_IDX_W-1:0] key_index;
        logic                 press_report;
    } out_item_t;

    // Decoder result handed to the output register.
    typedef struct packed {
        logic      emit;
        out_item_t item;
    } dec_result_t;

    typedef struct packed {
        logic                 found;
        logic [KEY_IDX_W-1:0] index;
    } key_hit_t;

    // Scan code set 2, standard keys in table order.
    localparam logic [CODE_W-1:0] STD_CODES [STD_COUNT] = '{
        8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34, 8'h33, 8'h43, 8'h3B,
        8'h42, 8'h4B, 8'h3A, 8'h31, 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C,
        8'h3C, 8'h2A, 8'h1D, 8'h22, 8'h35, 8'h1A, 8'h45, 8'h16, 8'h1E, 8'h26,
        8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46, 8'h0E, 8'h4E, 8'h55, 8'h5D,
        8'h66, 8'h29, 8'h0D, 8'h58, 8'h12, 8'h14, 8'h11, 8'h59, 8'h5A, 8'h76,
        8'h05, 8'h06, 8'h04, 8'h0C, 8'h03, 8'h0B, 8'h83, 8'h0A, 8'h01, 8'h09,
        8'h78, 8'h07, 8'h7E
    };

    // Keys that follow an extend prefix; their index starts after the standard keys.
    localparam logic [CODE_W-1:0] EXT_CODES [EXT_COUNT] = '{
        8'h1F, 8'h14, 8'h27, 8'h11, 8'h2F, 8'h12, 8'h7C, 8'h70, 8'h6C, 8'h7D,
        8'h71, 8'h69, 8'h7A, 8'h75, 8'h6B, 8'h74, 8'h72, 8'h4A, 8'h5A
    };

    // Table codes are unique, so the compares run in parallel.
    function automatic key_hit_t key_lookup(input logic [CODE_W-1:0] code, input logic ext);
        key_hit_t hit;
        hit = '0;
        if (ext)
        begin
            for (int i = 0; i < EXT_COUNT; i++)
            begin
                if (EXT_CODES[i] == code)
                begin
                    hit.found = 1'b1;
                    hit.index = KEY_IDX_W'(STD_COUNT + i);
                end
            end
        end
        else
        begin
            for (int i = 0; i < STD_COUNT; i++)
            begin
                if (STD_CODES[i] == code)
                begin
                    hit.found = 1'b1;
                    hit.index = KEY_IDX_W'(i);
                end
            end
        end
        return hit;
    endfunction

endpackage

// ===== hdl/ps2kbd_chan_if.sv =====
interface ps2kbd_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/ps2kbd_in_stage.sv =====
module ps2kbd_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  ps2kbd_pkg::in_item_t in_item,
    output logic                in_ready,
    input  logic                adv,
    output logic                s1_valid,
    output ps2kbd_pkg::in_item_t s1_item
);

    logic                 valid_reg;
    logic                 valid_next;
    ps2kbd_pkg::in_item_t item_reg;
    logic                 load;

    // Take a new item whenever the register is empty or the held one leaves in the same cycle.
    assign in_ready = !valid_reg || adv;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (adv)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

// ===== hdl/ps2kbd_decode.sv =====
module ps2kbd_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s1_valid,
    input  ps2kbd_pkg::in_item_t   s1_item,
    input  logic                   out_free,
    output logic                   adv,
    output ps2kbd_pkg::dec_result_t result
);

    logic                release_pending_reg;
    logic                release_pending_next;
    logic                extended_pending_reg;
    logic                extended_pending_next;
    ps2kbd_pkg::key_hit_t hit;
    logic                is_dev_byte;

    assign hit         = ps2kbd_pkg::key_lookup(s1_item.code_byte, extended_pending_reg);
    assign is_dev_byte = s1_item.is_byte && !s1_item.from_host;

    always_comb
    begin
        result = '0;
        result.item.scan_code    = s1_item.code_byte;
        result.item.extended_key = extended_pending_reg;
        if (is_dev_byte && s1_item.code_byte != ps2kbd_pkg::CODE_RELEASE
            && s1_item.code_byte != ps2kbd_pkg::CODE_EXTEND)
        begin
            result.emit = 1'b1;
            if (s1_item.code_byte == ps2kbd_pkg::CODE_ACK)
            begin
                result.item.event_kind = ps2kbd_pkg::EV_ACK;
            end
            else
            begin
                result.item.event_kind   = release_pending_reg ? ps2kbd_pkg::EV_RELEASE
                                                               : ps2kbd_pkg::EV_PRESS;
                result.item.key_found    = hit.found;
                result.item.key_index    = hit.index;
                result.item.press_report = hit.found && !release_pending_reg;
            end
        end
    end

    // Hold the item while its result cannot enter the output register.
    assign adv = s1_valid && (!result.emit || out_free);

    always_comb
    begin
        release_pending_next  = release_pending_reg;
        extended_pending_next = extended_pending_reg;
        if (adv && s1_item.is_byte)
        begin
            if (s1_item.from_host || result.emit)
            begin
                release_pending_next  = 1'b0;
                extended_pending_next = 1'b0;
            end
            else if (s1_item.code_byte == ps2kbd_pkg::CODE_RELEASE)
            begin
                release_pending_next = 1'b1;
            end
            else
            begin
                extended_pending_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_pending_reg  <= 1'b0;
            extended_pending_reg <= 1'b0;
        end
        else
        begin
            release_pending_reg  <= release_pending_next;
            extended_pending_reg <= extended_pending_next;
        end
    end

endmodule

// ===== hdl/ps2kbd_out_stage.sv =====
module ps2kbd_out_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  ps2kbd_pkg::dec_result_t result,
    output logic                    out_free,
    output logic                    out_valid,
    output ps2kbd_pkg::out_item_t   out_item,
    input  logic                    out_ready
);

    logic                  valid_reg;
    logic                  valid_next;
    ps2kbd_pkg::out_item_t item_reg;
    logic                  load;

    assign out_free = !valid_reg || out_ready;
    assign load     = adv && result.emit;

    always_comb
    begin
        valid_next = load || (valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result.item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== hdl/ps2_keyboard_scan_code_decoder.sv =====
// Channel   Dir  Payload                       Meaning
// in_ch     in   is_byte, code_byte, from_host  one PS/2 byte, device or host
// out_ch    out  event_kind .. press_report     press, release or ack event
//
// One item per cycle sustained while out_ch is ready: input register, table
// match and flag update, output register. A byte with an event waits in the
// input register until the output register is free; out_ch.valid then rises.
// Prefix, host and non-byte items produce no result and leave without waiting.
// rst_n clears the valid bits and the release / extend flags asynchronously.
// A stalled out_ch holds the input register only when its item has a result.
module ps2_keyboard_scan_code_decoder (
    input  logic         clk,
    input  logic         rst_n,
    ps2kbd_chan_if.sink   in_ch,
    ps2kbd_chan_if.source out_ch
);

    // Input register outputs
    logic                    s1_valid;
    ps2kbd_pkg::in_item_t    s1_item;
    ps2kbd_pkg::in_item_t    in_item;
    // Decode handshake: advance the held item, result toward the output register
    logic                    adv;
    logic                    out_free;
    ps2kbd_pkg::dec_result_t result;
    ps2kbd_pkg::out_item_t   out_item;
    logic                    in_ready;
    logic                    out_valid;

    assign in_item = in_ch.payload;

    ps2kbd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_item  (in_item),
        .in_ready (in_ready),
        .adv      (adv),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    // Track the release / extend prefixes and build the event.
    ps2kbd_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_item  (s1_item),
        .out_free (out_free),
        .adv      (adv),
        .result   (result)
    );

    // Hold the event until the sink takes it.
    ps2kbd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .result    (result),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_item  (out_item),
        .out_ready (out_ch.ready)
    );

    assign in_ch.ready    = in_ready;
    assign out_ch.valid   = out_valid;
    assign out_ch.payload = out_item;

`ifndef NO_ASSERTIONS
    // Only device bytes other than the prefixes may create an event.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.emit && s1_valid |-> s1_item.is_byte && !s1_item.from_host
            && s1_item.code_byte != ps2kbd_pkg::CODE_RELEASE
            && s1_item.code_byte != ps2kbd_pkg::CODE_EXTEND)
        else $error("event built from a byte that must not produce one");

    // An event that advances shows up on out_ch in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && result.emit |=> out_ch.valid)
        else $error("advanced event lost before the output register");

    // The input register never drops a held item while its event is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && result.emit && !out_free |=> s1_valid && $stable(s1_item))
        else $error("held item changed while its event was blocked");

    // A press report needs a known key pressed, never an ack.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_item.press_report |->
            out_item.key_found && out_item.event_kind == ps2kbd_pkg::EV_PRESS)
        else $error("press report without a found key press");
`endif

endmodule
